// ----- rtl/rsre_pkg.sv -----
`default_nettype none
package rsre_pkg;

	localparam logic [2:0] REG_DIRECT_RE0   = 3'd0;
	localparam logic [2:0] REG_DIRECT_IM0   = 3'd1;
	localparam logic [2:0] REG_DIRECT_RE1   = 3'd2;
	localparam logic [2:0] REG_DIRECT_IM1   = 3'd3;
	localparam logic [2:0] REG_POWER_NOISE  = 3'd4;

	localparam logic [15:0] AMP_OFFSET = 16'd14090;
	localparam logic [44:0] GAIN_MAX   = 45'h1FFF_FFFF_FFFF;
	localparam logic [43:0] PTN_RESET  = 44'd10000000000000;

	localparam logic [16:0] QSINE [17] = '{
		17'd0, 17'd3212, 17'd6393, 17'd9512, 17'd12540, 17'd15447, 17'd18205,
		17'd20788, 17'd23170, 17'd25330, 17'd27246, 17'd28899, 17'd30274,
		17'd31357, 17'd32138, 17'd32610, 17'd32768};

	localparam logic [15:0] BETA [17] = '{
		16'd6554, 16'd6864, 16'd7495, 16'd8354, 16'd9406, 16'd10630, 16'd12011,
		16'd13538, 16'd15201, 16'd16994, 16'd18912, 16'd20947, 16'd23098,
		16'd25358, 16'd27725, 16'd30196, 16'd32768};

	localparam logic [10:0] LOG_FRAC [33] = '{
		11'd0, 11'd45, 11'd90, 11'd132, 11'd174, 11'd214, 11'd254, 11'd292,
		11'd330, 11'd366, 11'd402, 11'd436, 11'd470, 11'd504, 11'd536, 11'd568,
		11'd599, 11'd629, 11'd659, 11'd689, 11'd717, 11'd745, 11'd773, 11'd800,
		11'd827, 11'd853, 11'd879, 11'd904, 11'd929, 11'd953, 11'd977, 11'd1001,
		11'd1024};

	typedef struct packed {
		logic signed [24:0] re0;
		logic signed [24:0] im0;
		logic signed [24:0] re1;
		logic signed [24:0] im1;
		logic               last;
	} rsre_elem_t;

	typedef struct packed {
		logic full;
		logic empty;
	} rsre_qstat_t;

	typedef struct packed {
		logic signed [15:0] dre0;
		logic signed [15:0] dim0;
		logic signed [15:0] dre1;
		logic signed [15:0] dim1;
		logic        [43:0] ptn;
	} rsre_cfg_t;

	function automatic logic signed [16:0] wave_point(input logic [6:0] k);
		logic [4:0] r;
		logic [4:0] rr;
		r  = {1'b0, k[3:0]};
		rr = 5'd16 - r;
		case (k[5:4])
			2'd0:    wave_point = $signed(QSINE[r]);
			2'd1:    wave_point = $signed(QSINE[rr]);
			2'd2:    wave_point = -$signed(QSINE[r]);
			default: wave_point = -$signed(QSINE[rr]);
		endcase
	endfunction

	function automatic logic signed [17:0] sine_interp(input logic [15:0] ang);
		logic signed [16:0] s0;
		logic signed [16:0] s1;
		logic signed [17:0] d;
		logic signed [28:0] p;
		logic signed [28:0] sh;
		s0 = wave_point({1'b0, ang[15:10]});
		s1 = wave_point(7'({1'b0, ang[15:10]} + 7'd1));
		d  = {s1[16], s1} - {s0[16], s0};
		p  = d * $signed({1'b0, ang[9:0]});
		sh = p >>> 10;
		sine_interp = {s0[16], s0} + sh[17:0];
	endfunction

	function automatic logic [15:0] amp_interp(input logic signed [17:0] s);
		logic [17:0] t;
		logic [15:0] x;
		logic [4:0]  idx;
		logic [15:0] d;
		logic [26:0] p;
		t   = $unsigned(s) + 18'd32768;
		x   = t[16:1];
		idx = x[15:11];
		if (idx >= 5'd16) begin
			amp_interp = BETA[16];
		end else begin
			d = BETA[5'(idx + 5'd1)] - BETA[idx];
			p = 27'(d) * 27'(x[10:0]);
			amp_interp = BETA[idx] + p[26:11];
		end
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		if (v > 34'sd2147483647)
			sat32 = 32'sh7FFF_FFFF;
		else if (v < -34'sd2147483648)
			sat32 = 32'sh8000_0000;
		else
			sat32 = v[31:0];
	endfunction

endpackage
`default_nettype wire

// ----- rtl/rsre_front.sv -----
`default_nettype none
module rsre_front
	import rsre_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [15:0] phase,
	input  wire logic signed [15:0] coef_re0,
	input  wire logic signed [15:0] coef_im0,
	input  wire logic signed [15:0] coef_re1,
	input  wire logic signed [15:0] coef_im1,
	input  wire logic               last,
	input  rsre_qstat_t             q_st,
	output logic                    q_push,
	output rsre_elem_t              q_data
);

	localparam logic [2:0] F_IDLE = 3'd0;
	localparam logic [2:0] F_SINE = 3'd1;
	localparam logic [2:0] F_BETA = 3'd2;
	localparam logic [2:0] F_AB   = 3'd3;
	localparam logic [2:0] F_P0   = 3'd4;
	localparam logic [2:0] F_P1   = 3'd5;
	localparam logic [2:0] F_PUSH = 3'd6;

	logic [2:0] state_q;
	logic [15:0] theta_q;
	logic signed [15:0] cr0_q, ci0_q, cr1_q, ci1_q;
	logic last_q;
	logic signed [17:0] sin_q, cos_q, samp_q;
	logic [15:0] beta_q;
	logic signed [16:0] a_q, b_q;
	rsre_elem_t elem_q;

	logic signed [34:0] pcos, psin;
	logic signed [35:0] nsin;
	logic signed [15:0] cr, ci;
	logic signed [32:0] m1, m2, m3, m4;
	logic signed [33:0] dre, dim;
	logic signed [33:0] sre, sim;

	assign in_stall = (state_q != F_IDLE);
	assign q_push   = (state_q == F_PUSH) && !q_st.full;
	assign q_data   = elem_q;

	always_comb begin
		pcos = $signed({1'b0, beta_q}) * cos_q;
		psin = $signed({1'b0, beta_q}) * sin_q;
		nsin = -36'(psin);
		cr   = (state_q == F_P0) ? cr0_q : cr1_q;
		ci   = (state_q == F_P0) ? ci0_q : ci1_q;
		m1   = a_q * cr;
		m2   = b_q * ci;
		m3   = a_q * ci;
		m4   = b_q * cr;
		dre  = 34'(m1) - 34'(m2);
		dim  = 34'(m3) + 34'(m4);
		sre  = dre >>> 9;
		sim  = dim >>> 9;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			unique case (state_q)
				F_IDLE: if (in_valid) state_q <= F_SINE;
				F_SINE: state_q <= F_BETA;
				F_BETA: state_q <= F_AB;
				F_AB:   state_q <= F_P0;
				F_P0:   state_q <= F_P1;
				F_P1:   state_q <= F_PUSH;
				F_PUSH: if (!q_st.full) state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && in_valid) begin
			theta_q <= $unsigned(phase);
			cr0_q   <= coef_re0;
			ci0_q   <= coef_im0;
			cr1_q   <= coef_re1;
			ci1_q   <= coef_im1;
			last_q  <= last;
		end
		if (state_q == F_SINE) begin
			sin_q  <= sine_interp(theta_q);
			cos_q  <= sine_interp(16'(theta_q + 16'd16384));
			samp_q <= sine_interp(16'(theta_q - AMP_OFFSET));
		end
		if (state_q == F_BETA)
			beta_q <= amp_interp(samp_q);
		if (state_q == F_AB) begin
			a_q <= 17'(pcos >>> 15);
			b_q <= 17'(nsin >>> 15);
		end
		if (state_q == F_P0) begin
			elem_q.re0 <= sre[24:0];
			elem_q.im0 <= sim[24:0];
		end
		if (state_q == F_P1) begin
			elem_q.re1  <= sre[24:0];
			elem_q.im1  <= sim[24:0];
			elem_q.last <= last_q;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/rsre_fifo.sv -----
`default_nettype none
module rsre_fifo
	import rsre_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  rsre_elem_t wdata,
	input  wire logic  pop,
	output rsre_elem_t rdata,
	output rsre_qstat_t st
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	rsre_elem_t mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign st.full  = (cnt_q == CW'(DEPTH));
	assign st.empty = (cnt_q == '0);
	assign rdata    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : PW'(wr_q + 1'b1);
			if (pop)
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : PW'(rd_q + 1'b1);
			if (push && !pop)
				cnt_q <= CW'(cnt_q + 1'b1);
			else if (pop && !push)
				cnt_q <= CW'(cnt_q - 1'b1);
		end
	end

endmodule
`default_nettype wire

// ----- rtl/rsre_back.sv -----
`default_nettype none
module rsre_back
	import rsre_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  rsre_cfg_t   cfg,
	input  rsre_qstat_t q_st,
	input  rsre_elem_t  q_data,
	output logic        q_pop,
	output logic        out_valid,
	input  wire logic   out_stall,
	output logic [44:0] channel_gain,
	output logic [15:0] rate
);

	localparam logic [2:0] B_IDLE = 3'd0;
	localparam logic [2:0] B_H    = 3'd1;
	localparam logic [2:0] B_SQ   = 3'd2;
	localparam logic [2:0] B_GSAT = 3'd3;
	localparam logic [2:0] B_MUL  = 3'd4;
	localparam logic [2:0] B_NORM = 3'd5;
	localparam logic [2:0] B_RATE = 3'd6;

	logic [2:0] state_q;
	logic signed [31:0] acc_q [4];
	logic signed [31:0] h_q [4];
	logic [1:0] j_q;
	logic [53:0] gsum_q;
	logic [44:0] gain_q;
	logic [1:0] gd_q;
	logic ph_q;
	logic [89:0] v_q;
	logic [6:0] lead_q;
	logic out_valid_q;
	logic [44:0] gain_out_q;
	logic [15:0] rate_out_q;

	logic signed [24:0] part [4];
	logic signed [15:0] dir [4];
	logic signed [63:0] sq;
	logic [14:0] gdig;
	logic [21:0] phalf;
	logic [36:0] pp;
	logic [6:0] psh;
	logic [89:0] term;
	logic [14:0] w;
	logic [5:0] lidx;
	logic [10:0] ldiff;
	logic [20:0] lprod;
	logic [16:0] rsum;
	logic load_out;

	assign q_pop        = (state_q == B_IDLE) && !q_st.empty;
	assign out_valid    = out_valid_q;
	assign channel_gain = gain_out_q;
	assign rate         = rate_out_q;
	assign load_out     = (state_q == B_RATE) && (!out_valid_q || !out_stall);

	always_comb begin
		part[0] = q_data.re0;
		part[1] = q_data.im0;
		part[2] = q_data.re1;
		part[3] = q_data.im1;
		dir[0]  = cfg.dre0;
		dir[1]  = cfg.dim0;
		dir[2]  = cfg.dre1;
		dir[3]  = cfg.dim1;
		sq      = h_q[j_q] * h_q[j_q];
		case (gd_q)
			2'd0:    gdig = gain_q[14:0];
			2'd1:    gdig = gain_q[29:15];
			default: gdig = gain_q[44:30];
		endcase
		phalf = ph_q ? cfg.ptn[43:22] : cfg.ptn[21:0];
		pp    = 37'(gdig) * 37'(phalf);
		case ({gd_q, ph_q})
			3'b000:  psh = 7'd0;
			3'b010:  psh = 7'd15;
			3'b100:  psh = 7'd30;
			3'b001:  psh = 7'd22;
			3'b011:  psh = 7'd37;
			default: psh = 7'd52;
		endcase
		term  = 90'(pp) << psh;
		w     = v_q[88:74];
		lidx  = {1'b0, w[14:10]};
		ldiff = LOG_FRAC[6'(lidx + 6'd1)] - LOG_FRAC[lidx];
		lprod = 21'(ldiff) * 21'(w[9:0]);
		rsum  = {7'(lead_q - 7'd28), 10'd0} + 17'(LOG_FRAC[lidx]) + 17'(lprod[20:10]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 4; i++)
				acc_q[i] <= '0;
			j_q  <= '0;
			gd_q <= '0;
			ph_q <= 1'b0;
		end else begin
			out_valid_q <= load_out || (out_valid_q && out_stall);
			unique case (state_q)
				B_IDLE: begin
					if (!q_st.empty) begin
						for (int i = 0; i < 4; i++)
							acc_q[i] <= sat32(34'(acc_q[i]) + 34'(part[i]));
						if (q_data.last)
							state_q <= B_H;
					end
				end
				B_H: begin
					for (int i = 0; i < 4; i++)
						acc_q[i] <= '0;
					j_q     <= '0;
					state_q <= B_SQ;
				end
				B_SQ: begin
					j_q <= 2'(j_q + 2'd1);
					if (j_q == 2'd3)
						state_q <= B_GSAT;
				end
				B_GSAT: begin
					gd_q    <= '0;
					ph_q    <= 1'b0;
					state_q <= B_MUL;
				end
				B_MUL: begin
					if (gd_q == 2'd2) begin
						gd_q <= '0;
						ph_q <= 1'b1;
						if (ph_q)
							state_q <= B_NORM;
					end else begin
						gd_q <= 2'(gd_q + 2'd1);
					end
				end
				B_NORM: if (v_q[89]) state_q <= B_RATE;
				B_RATE: if (load_out) state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_H) begin
			for (int i = 0; i < 4; i++)
				h_q[i] <= sat32(34'(acc_q[i]) + 34'($signed({dir[i], 6'd0})));
			gsum_q <= '0;
		end
		if (state_q == B_SQ)
			gsum_q <= gsum_q + 54'(sq[63:12]);
		if (state_q == B_GSAT) begin
			gain_q <= (gsum_q > 54'(GAIN_MAX)) ? GAIN_MAX : gsum_q[44:0];
			v_q    <= 90'd1 << 28;
			lead_q <= 7'd89;
		end
		if (state_q == B_MUL)
			v_q <= v_q + term;
		if (state_q == B_NORM && !v_q[89]) begin
			v_q    <= v_q << 1;
			lead_q <= 7'(lead_q - 7'd1);
		end
		if (load_out) begin
			gain_out_q <= gain_q;
			rate_out_q <= (rsum > 17'd65535) ? 16'hFFFF : rsum[15:0];
		end
	end

endmodule
`default_nettype wire

// ----- rtl/reflecting_surface_rate_eval.sv -----
`default_nettype none
// Channel   Direction  Handshake            Payload
// in        input      in_valid/in_stall    phase, coef_re0..coef_im1, last
// out       output     out_valid/out_stall  channel_gain, rate
// cfg       input      cfg_we               cfg_idx, cfg_data
//
// The front takes one item at a time, in_stall high until it is pushed: sine
// interpolation, amplitude, rotation, the shared complex multiply per coefficient
// pair, then a push that waits while the queue is full. The back adds each element
// it pops; a last item then goes through gain, the partial-product multiply,
// normalization and the rate. Reset clears control state and accumulators; the queue
// lets the front keep going while the back works on a result or waits on out_stall.
module reflecting_surface_rate_eval
	import rsre_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [15:0] phase,
	input  wire logic signed [15:0] coef_re0,
	input  wire logic signed [15:0] coef_im0,
	input  wire logic signed [15:0] coef_re1,
	input  wire logic signed [15:0] coef_im1,
	input  wire logic               last,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [44:0]             channel_gain,
	output logic [15:0]             rate,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_idx,
	input  wire logic [43:0]        cfg_data
);

	rsre_cfg_t   cfg_q;
	rsre_qstat_t q_st;
	rsre_elem_t  q_wdata, q_rdata;
	logic        q_push, q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dre0 <= '0;
			cfg_q.dim0 <= '0;
			cfg_q.dre1 <= '0;
			cfg_q.dim1 <= '0;
			cfg_q.ptn  <= PTN_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_DIRECT_RE0:  cfg_q.dre0 <= cfg_data[15:0];
				REG_DIRECT_IM0:  cfg_q.dim0 <= cfg_data[15:0];
				REG_DIRECT_RE1:  cfg_q.dre1 <= cfg_data[15:0];
				REG_DIRECT_IM1:  cfg_q.dim1 <= cfg_data[15:0];
				REG_POWER_NOISE: cfg_q.ptn  <= cfg_data;
				default: ;
			endcase
		end
	end

	rsre_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.phase    (phase),
		.coef_re0 (coef_re0),
		.coef_im0 (coef_im0),
		.coef_re1 (coef_re1),
		.coef_im1 (coef_im1),
		.last     (last),
		.q_st     (q_st),
		.q_push   (q_push),
		.q_data   (q_wdata)
	);

	rsre_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.st     (q_st)
	);

	rsre_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_st         (q_st),
		.q_data       (q_rdata),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.channel_gain (channel_gain),
		.rate         (rate)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("front took an item without going busy");

	a_queue_state: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_st.full && q_st.empty))
		else $error("queue full and empty at once");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_st.full))
		else $error("push into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_pop && q_st.empty))
		else $error("pop from empty queue");

endmodule
`default_nettype wire

// ----- tb/reflecting_surface_rate_eval_tb.sv -----
`default_nettype none
module reflecting_surface_rate_eval_tb
	import rsre_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE = 200;

	typedef struct {
		logic signed [15:0] ph;
		logic signed [15:0] cr0;
		logic signed [15:0] ci0;
		logic signed [15:0] cr1;
		logic signed [15:0] ci1;
		logic               lst;
	} elem_t;

	typedef struct {
		elem_t       e;
		bit          typed;
		logic [44:0] g;
		logic [15:0] r;
	} row_t;

	typedef struct {
		logic [44:0] g;
		logic [15:0] r;
	} rate_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic signed [15:0] phase = '0;
	logic signed [15:0] coef_re0 = '0;
	logic signed [15:0] coef_im0 = '0;
	logic signed [15:0] coef_re1 = '0;
	logic signed [15:0] coef_im1 = '0;
	logic               last = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [44:0]        channel_gain;
	logic [15:0]        rate;
	logic               cfg_we = 1'b0;
	logic [2:0]         cfg_idx = '0;
	logic [43:0]        cfg_data = '0;

	reflecting_surface_rate_eval u_top (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	rate_t   pending_rates[$];
	int      fails = 0;
	int      cycles = 0;
	bit      calm = 1'b0;
	int      stall_left = 0;
	longint  acc[4];
	longint  direct[4];
	longint  ptn;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic longint wave_pt(int unsigned k);
		int unsigned r;
		int unsigned q;
		r = k & 15;
		q = (k >> 4) & 3;
		case (q)
			0: return longint'(QSINE[r]);
			1: return longint'(QSINE[16 - r]);
			2: return -longint'(QSINE[r]);
			default: return -longint'(QSINE[16 - r]);
		endcase
	endfunction

	function automatic longint sine_of(logic [15:0] ang);
		longint s0;
		longint s1;
		longint f;
		s0 = wave_pt(ang[15:10]);
		s1 = wave_pt(int'(ang[15:10]) + 1);
		f = ang[9:0];
		return s0 + (((s1 - s0) * f) >>> 10);
	endfunction

	function automatic longint beta_of(logic [15:0] ang);
		logic [15:0] t;
		longint x;
		longint f;
		int idx;
		t = ang - AMP_OFFSET;
		x = (sine_of(t) + 32768) >>> 1;
		idx = int'(x >>> 11);
		f = x & 2047;
		if (idx >= 16)
			return longint'(BETA[16]);
		return longint'(BETA[idx])
			+ (((longint'(BETA[idx + 1]) - longint'(BETA[idx])) * f) >>> 11);
	endfunction

	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic logic [15:0] rate_q10(logic [44:0] gain, logic [43:0] ratio);
		logic [127:0] v;
		logic [14:0]  w;
		int lead;
		int idx;
		longint f;
		longint r;
		v = 128'(gain) * 128'(ratio) + (128'd1 << 28);
		lead = 0;
		for (int i = 0; i < 128; i++)
			if (v[i])
				lead = i;
		w = 15'(v >> (lead - 15));
		idx = w[14:10];
		f = w[9:0];
		r = longint'(lead - 28) * 1024 + longint'(LOG_FRAC[idx])
			+ (((longint'(LOG_FRAC[idx + 1]) - longint'(LOG_FRAC[idx])) * f) >>> 10);
		if (r > 65535)
			r = 65535;
		return 16'(r);
	endfunction

	function automatic bit apply_element(elem_t e, output rate_t res);
		longint beta;
		longint a;
		longint b;
		longint cr;
		longint ci;
		longint h;
		longint g;
		logic [15:0] c;
		c = e.ph + 16'd16384;
		beta = beta_of(e.ph);
		a = (beta * sine_of(c)) >>> 15;
		b = (-(beta * sine_of(e.ph))) >>> 15;
		for (int j = 0; j < 2; j++) begin
			cr = (j == 0) ? longint'(e.cr0) : longint'(e.cr1);
			ci = (j == 0) ? longint'(e.ci0) : longint'(e.ci1);
			acc[2 * j] = sat32(acc[2 * j] + ((a * cr - b * ci) >>> 9));
			acc[2 * j + 1] = sat32(acc[2 * j + 1] + ((a * ci + b * cr) >>> 9));
		end
		if (!e.lst)
			return 1'b0;
		g = 0;
		for (int j = 0; j < 4; j++) begin
			h = sat32(acc[j] + direct[j] * 64);
			g += (h * h) >>> 12;
			acc[j] = 0;
		end
		if (g > longint'(GAIN_MAX))
			g = longint'(GAIN_MAX);
		res.g = 45'(g);
		res.r = rate_q10(45'(g), 44'(ptn));
		return 1'b1;
	endfunction

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else begin
			out_stall <= 1'b0;
			if (!calm)
				stall_left <= pick_gap();
		end
	end

	always @(posedge clk) begin
		rate_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_rates.size() == 0) begin
				$error("result with nothing pending: gain %0d rate %0d", channel_gain, rate);
				fails++;
			end else begin
				want = pending_rates.pop_front();
				if (channel_gain !== want.g) begin
					$error("channel_gain expected %0d actual %0d", want.g, channel_gain);
					fails++;
				end
				if (rate !== want.r) begin
					$error("rate expected %0d actual %0d", want.r, rate);
					fails++;
				end
			end
		end
	end

	task automatic send_elem(elem_t e, bit typed = 1'b0, rate_t fixed = '{0, 0});
		int gap;
		rate_t res;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		phase <= e.ph;
		coef_re0 <= e.cr0;
		coef_im0 <= e.ci0;
		coef_re1 <= e.cr1;
		coef_im1 <= e.ci1;
		last <= e.lst;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (apply_element(e, res))
			pending_rates.insert(pending_rates.size(), typed ? fixed : res);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_rates.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [43:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_DIRECT_RE0: direct[0] = longint'($signed(data[15:0]));
			REG_DIRECT_IM0: direct[1] = longint'($signed(data[15:0]));
			REG_DIRECT_RE1: direct[2] = longint'($signed(data[15:0]));
			REG_DIRECT_IM1: direct[3] = longint'($signed(data[15:0]));
			REG_POWER_NOISE: ptn = longint'(data);
			default: ;
		endcase
	endtask

	function automatic elem_t mk(int ph, int cr0, int ci0, int cr1, int ci1, bit lst);
		elem_t e;
		e.ph = 16'(ph);
		e.cr0 = 16'(cr0);
		e.ci0 = 16'(ci0);
		e.cr1 = 16'(cr1);
		e.ci1 = 16'(ci1);
		e.lst = lst;
		return e;
	endfunction

	function automatic logic [15:0] rand_coef();
		case ($urandom_range(0, 9))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [43:0] rand44();
		return {12'($urandom), 32'($urandom)};
	endfunction

	task automatic set_config(int mode);
		logic [15:0] d;
		for (int i = 0; i < 4; i++) begin
			case (mode)
				0: d = 16'sh7FFF;
				1: d = 16'sh8000;
				2: d = 16'h0000;
				default: d = 16'($urandom);
			endcase
			write_reg(3'(i), {28'($urandom), d});
		end
		case (mode)
			0: write_reg(REG_POWER_NOISE, 44'hFFF_FFFF_FFFF);
			1: write_reg(REG_POWER_NOISE, 44'd0);
			2: write_reg(REG_POWER_NOISE, 44'd1);
			default: write_reg(REG_POWER_NOISE, rand44() >> $urandom_range(0, 43));
		endcase
		write_reg(3'($urandom_range(5, 7)), rand44());
	endtask

	row_t table_rows[$];

	function automatic void add_row(elem_t e, bit typed);
		row_t r;
		r.e = e;
		r.typed = typed;
		r.g = '0;
		r.r = '0;
		table_rows.insert(table_rows.size(), r);
	endfunction

	initial begin
		int sent;
		int len;
		int mode;
		elem_t e;
		for (int j = 0; j < 4; j++) begin
			acc[j] = 0;
			direct[j] = 0;
		end
		ptn = longint'(PTN_RESET);

		add_row(mk(0, 0, 0, 0, 0, 1), 1);
		add_row(mk(-32768, 32767, 32767, 32767, 32767, 1), 0);
		add_row(mk(32767, -32768, -32768, -32768, -32768, 1), 0);
		add_row(mk(16384, 32767, -32768, 0, 0, 0), 0);
		add_row(mk(-16384, 0, 0, 32767, -32768, 0), 0);
		add_row(mk(0, -32768, 32767, -32768, 32767, 1), 0);
		for (int i = 0; i < 4; i++)
			add_row(mk(0, 32767, 32767, 32767, 32767, i == 3), 0);
		add_row(mk(-1, 1, -1, 1, -1, 1), 0);
		add_row(mk(1, -1, 1, -1, 1, 1), 0);
		add_row(mk(-32768, 0, 0, 0, 0, 1), 1);
		add_row(mk(14090, 32767, 0, 0, 32767, 1), 0);
		add_row(mk(-18678, -1, -1, -1, -1, 1), 0);
		add_row(mk(30000, 12345, -12345, -20000, 20000, 1), 0);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (4) @(posedge clk);

		calm = 1'b1;
		foreach (table_rows[i])
			send_elem(table_rows[i].e, table_rows[i].typed, '{table_rows[i].g, table_rows[i].r});
		calm = 1'b0;
		drain();

		sent = 0;
		mode = 0;
		while (sent < 1650) begin
			if (sent >= mode * 200) begin
				drain();
				set_config(mode < 3 ? mode : 3);
				mode++;
			end
			calm = ($urandom_range(0, 3) == 0);
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
			for (int k = 0; k < len; k++) begin
				e.ph = ($urandom_range(0, 7) == 0) ? rand_coef() : 16'($urandom);
				e.cr0 = rand_coef();
				e.ci0 = rand_coef();
				e.cr1 = rand_coef();
				e.ci1 = rand_coef();
				e.lst = (k == len - 1);
				send_elem(e);
			end
			sent += len;
			if ($urandom_range(0, 49) == 0)
				drain();
		end
		calm = 1'b0;
		drain();

		if (fails == 0 && pending_rates.size() == 0) begin
			$display("PASS");
		end else begin
			if (pending_rates.size() != 0)
				$error("results still pending at end: %0d", pending_rates.size());
			$display("FAIL");
		end
		$finish;
	end

endmodule
`default_nettype wire
